FILE: sv/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

  localparam int CAPACITY  = 16;
  localparam int PRIO_W    = 8;
  localparam int DATA_W    = 32;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int STATUS_W  = 2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

  // request modes
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic load_req;  // capture the incoming word
    logic exec;      // apply the held request and load the result register
  } spq_cmd_t;

endpackage

FILE: sv/spq_ctrl.sv
`timescale 1ns / 1ps

module spq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output spq_pkg::spq_cmd_t cmd
);
  import spq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic exec_go;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  // result register must be free (or draining this cycle) before executing
  assign exec_go   = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  always_comb begin
    cmd.load_req = in_valid && in_ready;
    cmd.exec     = exec_go;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (exec_go) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: sv/spq_datapath.sv
`timescale 1ns / 1ps

module spq_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  spq_pkg::spq_cmd_t                     cmd,
  input  logic                                  in_mode,
  input  logic [spq_pkg::PRIO_W-1:0]            in_priority_req,
  input  logic signed [spq_pkg::DATA_W-1:0]     in_payload,
  output logic [spq_pkg::STATUS_W-1:0]          out_status,
  output logic [spq_pkg::PRIO_W-1:0]            out_priority,
  output logic signed [spq_pkg::DATA_W-1:0]     out_payload,
  output logic [spq_pkg::CNT_W-1:0]             out_occupancy
);
  import spq_pkg::*;

  // held request
  logic                     req_mode_r;
  logic [PRIO_W-1:0]        req_prio_r;
  logic signed [DATA_W-1:0] req_data_r;

  // sorted cell row, head at cell 0
  logic [PRIO_W-1:0]        prio_r [CAPACITY];
  logic signed [DATA_W-1:0] data_r [CAPACITY];
  logic [PRIO_W-1:0]        prio_nxt [CAPACITY];
  logic signed [DATA_W-1:0] data_nxt [CAPACITY];

  logic [CNT_W-1:0]         cnt_r, cnt_nxt;

  logic [STATUS_W-1:0]      status_r, status_nxt;
  logic [PRIO_W-1:0]        rprio_r, rprio_nxt;
  logic signed [DATA_W-1:0] rdata_r, rdata_nxt;
  logic [CNT_W-1:0]         occ_r;

  logic [CAPACITY-1:0]      ge;
  logic                     full, empty;

  assign full  = (cnt_r == CNT_W'(CAPACITY));
  assign empty = (cnt_r == '0);

  // every cell compares against the new priority at once
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ge[i] = (CNT_W'(i) < cnt_r) && (prio_r[i] >= req_prio_r);
    end
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    status_nxt = ST_OK;
    rprio_nxt  = '0;
    rdata_nxt  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      prio_nxt[i] = prio_r[i];
      data_nxt[i] = data_r[i];
    end
    if (req_mode_r == MODE_INSERT) begin
      if (full) begin
        status_nxt = ST_OVERFLOW;
      end else begin
        // head cell takes the new entry when it does not outrank it
        if (!ge[0]) begin
          prio_nxt[0] = req_prio_r;
          data_nxt[0] = req_data_r;
        end
        for (int i = 1; i < CAPACITY; i++) begin
          if (!ge[i]) begin
            if (ge[i-1]) begin
              prio_nxt[i] = req_prio_r;
              data_nxt[i] = req_data_r;
            end else begin
              prio_nxt[i] = prio_r[i-1];
              data_nxt[i] = data_r[i-1];
            end
          end
        end
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        status_nxt = ST_UNDERFLOW;
      end else begin
        rprio_nxt = prio_r[0];
        rdata_nxt = data_r[0];
        for (int i = 0; i < CAPACITY - 1; i++) begin
          prio_nxt[i] = prio_r[i+1];
          data_nxt[i] = data_r[i+1];
        end
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_mode_r <= in_mode;
      req_prio_r <= in_priority_req;
      req_data_r <= in_payload;
    end
    if (cmd.exec) begin
      for (int i = 0; i < CAPACITY; i++) begin
        prio_r[i] <= prio_nxt[i];
        data_r[i] <= data_nxt[i];
      end
      status_r <= status_nxt;
      rprio_r  <= rprio_nxt;
      rdata_r  <= rdata_nxt;
      occ_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.exec) begin
      cnt_r <= cnt_nxt;
    end
  end

  assign out_status    = status_r;
  assign out_priority  = rprio_r;
  assign out_payload   = rdata_r;
  assign out_occupancy = occ_r;

endmodule

FILE: sv/sorted_priority_queue.sv
`timescale 1ns / 1ps

// sorted_priority_queue: a 16-entry priority queue held as a row of cells
// sorted from head (cell 0) to tail, larger priority first, first in first
// out among equal priorities. mode 0 inserts {priority_req, payload};
// mode 1 removes the head and returns it on out_priority / out_payload.
// every word in gives exactly one word out with a status (ok, underflow on
// remove from empty, overflow on insert into full, the entry then dropped)
// and the occupancy after the operation. each item is first captured in the
// request register, then executed: all cells compare against the new
// priority in parallel and shift in one step. the result sits in an output
// register, so the next word is taken while a result still waits; a
// stalled result only holds back the execute cycle of the following item.
// no clearing pass after reset: cells beyond the fill count are masked from the compare and never returned.

module sorted_priority_queue (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // request channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_mode,
  input  logic [spq_pkg::PRIO_W-1:0]            in_priority_req,
  input  logic signed [spq_pkg::DATA_W-1:0]     in_payload,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [spq_pkg::STATUS_W-1:0]          out_status,
  output logic [spq_pkg::PRIO_W-1:0]            out_priority,
  output logic signed [spq_pkg::DATA_W-1:0]     out_payload,
  output logic [spq_pkg::CNT_W-1:0]             out_occupancy
);
  import spq_pkg::*;

  // command bundle from the sequencer to the cell row
  spq_cmd_t cmd;

  // sequencer: capture, execute, hold result
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // sorted cells, fill count and result register
  spq_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_mode         (in_mode),
    .in_priority_req (in_priority_req),
    .in_payload      (in_payload),
    .out_status      (out_status),
    .out_priority    (out_priority),
    .out_payload     (out_payload),
    .out_occupancy   (out_occupancy)
  );

endmodule
